// ----- design/mwo_pkg.sv -----
`default_nettype none
package mwo_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_PHASE_BITS = 32;
	localparam int DEF_MAX_TICKS  = 255;

	// Fixed field widths
	localparam int TICK_W   = 8;
	localparam int SAMPLE_W = 16;
	localparam int NOISE_W  = 16;
	localparam int WAVE_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED  = 3'd4;

	// Waveform codes
	localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd0;
	localparam logic [WAVE_W-1:0] WAVE_SAWTOOTH = 3'd1;
	localparam logic [WAVE_W-1:0] WAVE_PULSE    = 3'd2;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd3;
	localparam logic [WAVE_W-1:0] WAVE_NOISE    = 3'd4;

	// Noise generator constants
	localparam logic [NOISE_W-1:0] LFSR_MASK  = 16'hB400;
	localparam logic [NOISE_W-1:0] LFSR_RESET = 16'hB400;
	localparam logic [NOISE_W-1:0] SEED_RESET = 16'h0001;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'hFFFF;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_NOISE,
		ST_DONE
	} mwo_state_t;

	// Waveform settings seen by the shaper
	typedef struct packed {
		logic                enable;
		logic [WAVE_W-1:0]   waveform;
		logic [SAMPLE_W-1:0] pulse_width;
	} mwo_wave_cfg_t;

endpackage
`default_nettype wire

// ----- design/mwo_mul.sv -----
`default_nettype none
// Shift-add unit: total = phase + ticks * increment, one tick bit per cycle.
module mwo_mul #(
	parameter int PHASE_BITS = mwo_pkg::DEF_PHASE_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 load,
	input  wire logic [PHASE_BITS-1:0]                phase_in,
	input  wire logic [PHASE_BITS-1:0]                inc_in,
	input  wire logic [mwo_pkg::TICK_W-1:0]           ticks_in,
	output logic                                      done,
	output logic [PHASE_BITS+mwo_pkg::TICK_W-1:0]     total
);
	localparam int ACC_W = PHASE_BITS + mwo_pkg::TICK_W;

	logic [ACC_W-1:0]           acc_q;
	logic [ACC_W-1:0]           mcand_q;
	logic [mwo_pkg::TICK_W-1:0] mplier_q;

	// Clear the multiplier bits so an idle unit reports done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mplier_q <= '0;
		end else if (load) begin
			mplier_q <= ticks_in;
		end else if (mplier_q != '0) begin
			mplier_q <= mplier_q >> 1;
		end
	end

	// Add the shifted increment for each set tick bit
	always_ff @(posedge clk) begin
		if (load) begin
			acc_q   <= ACC_W'(phase_in);
			mcand_q <= ACC_W'(inc_in);
		end else if (mplier_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
		end
	end

	assign done  = (mplier_q == '0);
	assign total = acc_q;

endmodule
`default_nettype wire

// ----- design/mwo_lfsr.sv -----
`default_nettype none
// Galois noise register, one step per strobe, reload from seed (SEED_RESET if the seed is zero) on zero.
module mwo_lfsr (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic [mwo_pkg::NOISE_W-1:0]   seed,
	output logic [mwo_pkg::NOISE_W-1:0]        noise
);
	logic [mwo_pkg::NOISE_W-1:0] noise_q;
	logic [mwo_pkg::NOISE_W-1:0] next_noise;

	// Shift right, fold in the mask, never stay at zero
	always_comb begin
		next_noise = (noise_q >> 1) ^ (noise_q[0] ? mwo_pkg::LFSR_MASK : '0);
		if (next_noise == '0) begin
			next_noise = (seed != '0) ? seed : mwo_pkg::SEED_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= mwo_pkg::LFSR_RESET;
		end else if (step) begin
			noise_q <= next_noise;
		end
	end

	assign noise = noise_q;

endmodule
`default_nettype wire

// ----- design/mwo_shape.sv -----
`default_nettype none
// Waveform shaper: sample of the selected wave at the current phase.
module mwo_shape #(
	parameter int PHASE_BITS = mwo_pkg::DEF_PHASE_BITS
) (
	input  wire logic [PHASE_BITS-1:0]          phase,
	input  wire logic [mwo_pkg::NOISE_W-1:0]    noise,
	input  wire mwo_pkg::mwo_wave_cfg_t         cfg,
	output logic [mwo_pkg::SAMPLE_W-1:0]        sample
);
	localparam int SW = mwo_pkg::SAMPLE_W;

	logic [PHASE_BITS:0]  phase_x2;
	logic [SW:0]          tri_up;
	logic [SW:0]          tri_down;
	logic [SW-1:0]        saw;

	assign phase_x2 = {phase, 1'b0};
	assign tri_up   = phase_x2[PHASE_BITS -: SW+1];
	assign tri_down = (SW+1)'(0) - tri_up;
	assign saw      = phase[PHASE_BITS-1 -: SW];

	// Select the wave; codes without meaning give silence
	always_comb begin
		sample = '0;
		if (cfg.enable) begin
			case (cfg.waveform)
				mwo_pkg::WAVE_TRIANGLE: begin
					if (!phase[PHASE_BITS-1]) begin
						sample = tri_up[SW-1:0];
					end else begin
						sample = tri_down[SW] ? mwo_pkg::FULL_SCALE : tri_down[SW-1:0];
					end
				end
				mwo_pkg::WAVE_SAWTOOTH: sample = saw;
				mwo_pkg::WAVE_PULSE:
					sample = (saw < cfg.pulse_width) ? mwo_pkg::FULL_SCALE : '0;
				mwo_pkg::WAVE_SQUARE:
					sample = phase[PHASE_BITS-1] ? '0 : mwo_pkg::FULL_SCALE;
				mwo_pkg::WAVE_NOISE:
					sample = {noise[7:0], noise[7:0]};
				default: sample = '0;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/multi_waveform_oscillator_core.sv -----
`default_nettype none
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------
// input    | in        | in_valid / in_stall | tick_count[7:0]
// result   | out       | out_valid/out_stall | sample[15:0], wrapped
// config   | in        | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[31:0]
//
// An item enters the sequencer, then runs in the shift-add unit (one tick bit per
// step up to the highest set bit, then the total is taken; skipped when the
// oscillator is stopped), takes one noise step per phase wrap in noise mode (up
// to 255 wraps), and then moves to the output register.
// in_stall is high from acceptance until the result moves to the output register.
// The output register lets the next item enter while a result waits on out_stall.
// Reset is asynchronous; there is no clearing pass. cfg_ready is always high.
module multi_waveform_oscillator_core #(
	parameter int PHASE_BITS = mwo_pkg::DEF_PHASE_BITS,
	parameter int MAX_TICKS  = mwo_pkg::DEF_MAX_TICKS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mwo_pkg::TICK_W-1:0]        tick_count,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [mwo_pkg::SAMPLE_W-1:0]           sample,
	output logic                                   wrapped,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mwo_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mwo_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int TW    = mwo_pkg::TICK_W;
	localparam int ACC_W = PHASE_BITS + TW;

	// Configuration registers
	logic                          enable_q;
	logic [mwo_pkg::WAVE_W-1:0]    waveform_q;
	logic [PHASE_BITS-1:0]         inc_q;
	logic [mwo_pkg::SAMPLE_W-1:0]  pulse_width_q;
	logic [mwo_pkg::NOISE_W-1:0]   seed_q;

	// Datapath and control state
	mwo_pkg::mwo_state_t           state_q, state_d;
	logic [PHASE_BITS-1:0]         phase_q;
	logic [TW-1:0]                 wraps_q;
	logic                          wrapped_q;
	logic                          stopped_q;
	logic                          out_valid_q;
	logic [mwo_pkg::SAMPLE_W-1:0]  sample_q;
	logic                          wrapped_out_q;

	logic                          in_take;
	logic                          cfg_take;
	logic [PHASE_BITS-1:0]         cfg_inc;
	logic [TW-1:0]                 ticks_sat;
	logic                          mul_load;
	logic                          mul_done;
	logic [ACC_W-1:0]              mul_total;
	logic [TW-1:0]                 mul_wraps;
	logic                          lfsr_step;
	logic [mwo_pkg::NOISE_W-1:0]   noise;
	logic [mwo_pkg::SAMPLE_W-1:0]  shape_sample;
	logic [mwo_pkg::SAMPLE_W-1:0]  result_sample;
	logic                          out_load;
	mwo_pkg::mwo_wave_cfg_t        wave_cfg;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign cfg_inc   = PHASE_BITS'(cfg_data);
	assign in_stall  = (state_q != mwo_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign ticks_sat = ((TW+9)'(tick_count) > (TW+9)'(MAX_TICKS))
		? TW'(MAX_TICKS) : tick_count;
	assign mul_wraps = mul_total[ACC_W-1 -: TW];
	assign mul_load  = in_take && (inc_q != '0);
	assign lfsr_step = (state_q == mwo_pkg::ST_NOISE);
	assign out_load  = (state_q == mwo_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			waveform_q    <= mwo_pkg::WAVE_TRIANGLE;
			inc_q         <= '0;
			pulse_width_q <= '0;
			seed_q        <= mwo_pkg::SEED_RESET;
		end else if (cfg_take) begin
			case (cfg_index)
				mwo_pkg::REG_ENABLE:      enable_q      <= cfg_data[0];
				mwo_pkg::REG_WAVEFORM:    waveform_q    <= cfg_data[mwo_pkg::WAVE_W-1:0];
				mwo_pkg::REG_PHASE_INC:   inc_q         <= cfg_inc;
				mwo_pkg::REG_PULSE_WIDTH: pulse_width_q <= cfg_data[mwo_pkg::SAMPLE_W-1:0];
				mwo_pkg::REG_NOISE_SEED:  seed_q        <= cfg_data[mwo_pkg::NOISE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mwo_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = (inc_q != '0) ? mwo_pkg::ST_MUL : mwo_pkg::ST_DONE;
				end
			end
			mwo_pkg::ST_MUL: begin
				if (mul_done) begin
					if (waveform_q == mwo_pkg::WAVE_NOISE && mul_wraps != '0) begin
						state_d = mwo_pkg::ST_NOISE;
					end else begin
						state_d = mwo_pkg::ST_DONE;
					end
				end
			end
			mwo_pkg::ST_NOISE: begin
				if (wraps_q == TW'(1)) begin
					state_d = mwo_pkg::ST_DONE;
				end
			end
			mwo_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = mwo_pkg::ST_IDLE;
				end
			end
			default: state_d = mwo_pkg::ST_IDLE;
		endcase
	end

	// Phase accumulator; a zero increment write parks it at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cfg_take && cfg_index == mwo_pkg::REG_PHASE_INC && cfg_inc == '0) begin
			phase_q <= '0;
		end else if (state_q == mwo_pkg::ST_MUL && mul_done) begin
			phase_q <= mul_total[PHASE_BITS-1:0];
		end
	end

	// Hold per-item flags and count down noise steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wraps_q   <= '0;
			wrapped_q <= 1'b0;
			stopped_q <= 1'b0;
		end else if (in_take) begin
			wrapped_q <= 1'b0;
			stopped_q <= (inc_q == '0);
			wraps_q   <= '0;
		end else if (state_q == mwo_pkg::ST_MUL && mul_done) begin
			wraps_q   <= mul_wraps;
			wrapped_q <= (mul_wraps != '0);
		end else if (lfsr_step) begin
			wraps_q <= wraps_q - TW'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_q      <= result_sample;
			wrapped_out_q <= wrapped_q;
		end
	end

	assign result_sample = stopped_q ? '0 : shape_sample;
	assign out_valid     = out_valid_q;
	assign sample        = sample_q;
	assign wrapped       = wrapped_out_q;

	assign wave_cfg.enable      = enable_q;
	assign wave_cfg.waveform    = waveform_q;
	assign wave_cfg.pulse_width = pulse_width_q;

	mwo_mul #(
		.PHASE_BITS(PHASE_BITS)
	) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (mul_load),
		.phase_in (phase_q),
		.inc_in   (inc_q),
		.ticks_in (ticks_sat),
		.done     (mul_done),
		.total    (mul_total)
	);

	mwo_lfsr u_lfsr (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (lfsr_step),
		.seed   (seed_q),
		.noise  (noise)
	);

	mwo_shape #(
		.PHASE_BITS(PHASE_BITS)
	) u_shape (
		.phase  (phase_q),
		.noise  (noise),
		.cfg    (wave_cfg),
		.sample (shape_sample)
	);

	// A running oscillator sends the item through the shift-add unit
	a_run_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && inc_q != '0 |=> state_q == mwo_pkg::ST_MUL)
		else $error("item with nonzero increment did not start the multiply");

	// A stopped oscillator reports silence and no wrap
	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && stopped_q |=> sample == '0 && !wrapped)
		else $error("stopped oscillator produced output");

	// Noise stepping only runs with wraps left to count
	a_noise_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mwo_pkg::ST_NOISE |-> wraps_q != '0 && waveform_q == mwo_pkg::WAVE_NOISE)
		else $error("noise step without pending wrap");

	// A disabled oscillator stores a zero sample
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !enable_q |=> sample == '0)
		else $error("disabled oscillator produced nonzero sample");

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mwo_pkg::*;

	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 300;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTINGS_PER_MODE = 8;
	localparam int ITEMS_PER_SETTING = 56;
	// Indexes past the last register: writes there are ignored
	localparam logic [CFG_IDX_W-1:0] NO_REG_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] NO_REG_HI = 3'd7;

	typedef struct packed {
		logic [SAMPLE_W-1:0] level;
		logic                wrap;
	} osc_out_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [TICK_W-1:0]     ticks;
		bit                    known;
		osc_out_t              want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [TICK_W-1:0]     tick_count;
	logic                  out_valid;
	logic                  out_stall;
	logic [SAMPLE_W-1:0]   sample;
	logic                  wrapped;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Oscillator copy: settings and running state
	logic                  set_enable;
	logic [WAVE_W-1:0]     set_wave;
	logic [31:0]           set_inc;
	logic [SAMPLE_W-1:0]   set_width;
	logic [NOISE_W-1:0]    set_seed;
	logic [31:0]           osc_phase;
	logic [NOISE_W-1:0]    noise_lfsr;

	osc_out_t  expected_out[$];
	stim_row_t directed_rows[$];

	int send_pct;
	int recv_pct;
	int hold_seq;
	int hold_seen;
	int hold_left;
	int error_count;
	int items_sent;
	int results_seen;
	int wraps_seen;
	int reg_writes;
	int settings_run;
	int cycle_count;

	multi_waveform_oscillator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.tick_count (tick_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.wrapped    (wrapped),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// One step of the Galois noise register, reload on zero
	function automatic logic [NOISE_W-1:0] step_lfsr(input logic [NOISE_W-1:0] cur);
		logic [NOISE_W-1:0] nxt;
		nxt = cur >> 1;
		if (cur[0]) begin
			nxt ^= LFSR_MASK;
		end
		if (nxt == '0) begin
			nxt = (set_seed != '0) ? set_seed : SEED_RESET;
		end
		return nxt;
	endfunction

	// Wave value at the current phase
	function automatic logic [SAMPLE_W-1:0] shape_sample();
		logic [16:0] ramp;
		logic [17:0] fold;
		ramp = osc_phase[31:15];
		fold = 18'h20000 - 18'(ramp);
		case (set_wave)
			WAVE_TRIANGLE: begin
				if (!osc_phase[31]) begin
					return ramp[15:0];
				end
				return (fold > 18'hFFFF) ? FULL_SCALE : fold[15:0];
			end
			WAVE_SAWTOOTH: return osc_phase[31:16];
			WAVE_PULSE:    return (osc_phase < {set_width, 16'h0000}) ? FULL_SCALE : '0;
			WAVE_SQUARE:   return osc_phase[31] ? '0 : FULL_SCALE;
			WAVE_NOISE:    return {noise_lfsr[7:0], noise_lfsr[7:0]};
			default:       return '0;
		endcase
	endfunction

	// Advance the phase by ticks times the increment and form the result
	task automatic advance_oscillator(input logic [TICK_W-1:0] ticks, output osc_out_t res);
		logic [63:0] total;
		logic [31:0] wraps;
		res = '0;
		if (set_inc == '0) begin
			return;
		end
		total = {32'd0, osc_phase} + 64'(ticks) * {32'd0, set_inc};
		wraps = total[63:32];
		osc_phase = total[31:0];
		if (set_wave == WAVE_NOISE) begin
			repeat (wraps) noise_lfsr = step_lfsr(noise_lfsr);
		end
		res.wrap = (wraps != '0);
		if (set_enable) begin
			res.level = shape_sample();
		end
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ENABLE:      set_enable = data[0];
			REG_WAVEFORM:    set_wave = data[WAVE_W-1:0];
			REG_PHASE_INC: begin
				set_inc = data;
				// a zero increment also clears the phase
				if (data == '0) begin
					osc_phase = '0;
				end
			end
			REG_PULSE_WIDTH: set_width = data[SAMPLE_W-1:0];
			REG_NOISE_SEED:  set_seed = data[NOISE_W-1:0];
			default: ;
		endcase
	endtask

	// Write one register; cfg_valid stays high for the caller to drop
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		reg_writes++;
	endtask

	// Offer one item, idling at random first; predict on acceptance
	task automatic send_ticks(input logic [TICK_W-1:0] ticks, input bit known,
			input osc_out_t want);
		osc_out_t res;
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_pct);
		end
		in_valid   <= 1'b1;
		tick_count <= ticks;
		do @(posedge clk); while (in_stall);
		advance_oscillator(ticks, res);
		expected_out.push_back(known ? want : res);
		items_sent++;
	endtask

	// Drop valid and wait for every expected result, then let the block settle
	task automatic settle(input int cycles);
		in_valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row = '{ROW_CFG, idx, data, '0, 1'b0, '0};
		return row;
	endfunction

	function automatic stim_row_t item_row(input logic [TICK_W-1:0] ticks);
		stim_row_t row;
		row = '{ROW_ITEM, '0, '0, ticks, 1'b0, '0};
		return row;
	endfunction

	function automatic stim_row_t known_row(input logic [TICK_W-1:0] ticks,
			input logic [SAMPLE_W-1:0] lvl, input logic wrap);
		stim_row_t row;
		row = '{ROW_ITEM, '0, '0, ticks, 1'b1, '{lvl, wrap}};
		return row;
	endfunction

	task automatic build_directed();
		// stopped after reset
		directed_rows.push_back(known_row(8'hFF, 16'h0000, 1'b0));
		// sawtooth at 1/256 of a period per tick
		directed_rows.push_back(cfg_row(REG_ENABLE, 32'h1));
		directed_rows.push_back(cfg_row(REG_WAVEFORM, 32'(WAVE_SAWTOOTH)));
		directed_rows.push_back(cfg_row(REG_PHASE_INC, 32'h0100_0000));
		directed_rows.push_back(known_row(8'h00, 16'h0000, 1'b0));
		directed_rows.push_back(known_row(8'h01, 16'h0100, 1'b0));
		directed_rows.push_back(known_row(8'hFF, 16'h0000, 1'b1));
		// square around the half period
		directed_rows.push_back(cfg_row(REG_WAVEFORM, 32'(WAVE_SQUARE)));
		directed_rows.push_back(known_row(8'd128, 16'h0000, 1'b0));
		directed_rows.push_back(item_row(8'd127));
		directed_rows.push_back(known_row(8'd1, FULL_SCALE, 1'b1));
		// triangle peak saturates
		directed_rows.push_back(cfg_row(REG_WAVEFORM, 32'(WAVE_TRIANGLE)));
		directed_rows.push_back(known_row(8'd128, FULL_SCALE, 1'b0));
		directed_rows.push_back(item_row(8'd64));
		directed_rows.push_back(known_row(8'd64, 16'h0000, 1'b1));
		// pulse at widest and narrowest
		directed_rows.push_back(cfg_row(REG_WAVEFORM, 32'(WAVE_PULSE)));
		directed_rows.push_back(cfg_row(REG_PULSE_WIDTH, 32'hFFFF));
		directed_rows.push_back(item_row(8'hFF));
		directed_rows.push_back(cfg_row(REG_PULSE_WIDTH, 32'h0));
		directed_rows.push_back(known_row(8'd1, 16'h0000, 1'b1));
		// disabled: phase moves, sample zero
		directed_rows.push_back(cfg_row(REG_ENABLE, 32'h0));
		directed_rows.push_back(known_row(8'd200, 16'h0000, 1'b0));
		// noise at the largest increment, many wraps per step
		directed_rows.push_back(cfg_row(REG_ENABLE, 32'h1));
		directed_rows.push_back(cfg_row(REG_WAVEFORM, 32'(WAVE_NOISE)));
		directed_rows.push_back(cfg_row(REG_NOISE_SEED, 32'hACE1));
		directed_rows.push_back(cfg_row(REG_PHASE_INC, 32'hFFFF_FFFF));
		directed_rows.push_back(item_row(8'hFF));
		directed_rows.push_back(item_row(8'h01));
		directed_rows.push_back(item_row(8'h00));
		// waveform code without meaning
		directed_rows.push_back(cfg_row(REG_WAVEFORM, 32'hFFFF_FFFF));
		directed_rows.push_back(item_row(8'd3));
		// zero seed, writes to missing registers, zero increment clears phase
		directed_rows.push_back(cfg_row(REG_NOISE_SEED, 32'h0));
		directed_rows.push_back(cfg_row(NO_REG_LO, 32'hDEAD_BEEF));
		directed_rows.push_back(cfg_row(NO_REG_HI, 32'hFFFF_FFFF));
		directed_rows.push_back(cfg_row(REG_PHASE_INC, 32'h0));
		directed_rows.push_back(known_row(8'd9, 16'h0000, 1'b0));
		// smallest increment starts from the cleared phase
		directed_rows.push_back(cfg_row(REG_WAVEFORM, 32'(WAVE_SAWTOOTH)));
		directed_rows.push_back(cfg_row(REG_PHASE_INC, 32'h1));
		directed_rows.push_back(known_row(8'hFF, 16'h0000, 1'b0));
	endtask

	task automatic walk_directed();
		bit cfg_open;
		cfg_open = 1'b0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					settle(SETTLE_CYCLES);
					cfg_open = 1'b1;
				end
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				if (cfg_open) begin
					cfg_valid <= 1'b0;
					cfg_open = 1'b0;
				end
				send_ticks(directed_rows[i].ticks, directed_rows[i].known, directed_rows[i].want);
			end
		end
	endtask

	// Pick and write a full random setting, extremes included
	task automatic program_setting();
		logic [31:0] r;
		logic [31:0] inc;
		logic [15:0] width;
		logic [15:0] seed;
		logic [WAVE_W-1:0] wave;
		int pick;
		settle(SETTLE_CYCLES);
		r = $urandom();
		write_reg(REG_ENABLE, {r[31:1], ($urandom_range(99) < 85) ? 1'b1 : 1'b0});
		pick = $urandom_range(11);
		wave = (pick < 10) ? WAVE_W'(pick % 5) : WAVE_W'(5 + $urandom_range(2));
		r = $urandom();
		write_reg(REG_WAVEFORM, {r[31:WAVE_W], wave});
		case ($urandom_range(3))
			0: width = '0;
			1: width = 16'hFFFF;
			default: width = 16'($urandom());
		endcase
		r = $urandom();
		write_reg(REG_PULSE_WIDTH, {r[31:16], width});
		case ($urandom_range(3))
			0: seed = '0;
			1: seed = 16'hFFFF;
			2: seed = SEED_RESET;
			default: seed = 16'($urandom());
		endcase
		r = $urandom();
		write_reg(REG_NOISE_SEED, {r[31:16], seed});
		case ($urandom_range(9))
			0: inc = '0;
			1: inc = '1;
			2: inc = 32'd1;
			3, 4, 5: inc = $urandom_range(1 << 26, 1);
			default: inc = $urandom();
		endcase
		write_reg(REG_PHASE_INC, inc);
		if ($urandom_range(3) == 0) begin
			write_reg(NO_REG_LO + CFG_IDX_W'($urandom_range(2)), $urandom());
		end
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [TICK_W-1:0] pick_ticks();
		case ($urandom_range(19))
			0: return '0;
			1: return '1;
			default: return TICK_W'($urandom_range(255));
		endcase
	endfunction

	task automatic run_random();
		osc_out_t none;
		none = '0;
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 83; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 83; end
				default: begin send_pct = 29; recv_pct = 29; end
			endcase
			for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
				program_setting();
				// long receiver hold while items keep coming
				if (mode == 0 && s == 2) begin
					hold_seq <= hold_seq + 1;
				end
				repeat (ITEMS_PER_SETTING) send_ticks(pick_ticks(), 1'b0, none);
			end
		end
	endtask

	// Check each item leaving the block, then choose the next stall
	always @(posedge clk) begin
		osc_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_out.size() == 0) begin
				flag_error($sformatf("result with nothing expected: sample %h wrapped %b",
					sample, wrapped));
			end else begin
				want = expected_out.pop_front();
				results_seen++;
				if (want.wrap) begin
					wraps_seen++;
				end
				if (sample !== want.level) begin
					flag_error($sformatf("sample %h, expected %h", sample, want.level));
				end
				if (wrapped !== want.wrap) begin
					flag_error($sformatf("wrapped %b, expected %b", wrapped, want.wrap));
				end
			end
		end
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
		end
	end

	// Stop a run that hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_out.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		tick_count = '0;
		out_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		set_enable = 1'b0;
		set_wave   = WAVE_TRIANGLE;
		set_inc    = '0;
		set_width  = '0;
		set_seed   = SEED_RESET;
		osc_phase  = '0;
		noise_lfsr = LFSR_RESET;
		send_pct   = 0;
		recv_pct   = 0;
		hold_seq   = 0;
		hold_seen  = 0;
		hold_left  = 0;
		error_count  = 0;
		items_sent   = 0;
		results_seen = 0;
		wraps_seen   = 0;
		reg_writes   = 0;
		settings_run = 0;
		cycle_count  = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed();
		walk_directed();
		run_random();
		settle(TAIL_CYCLES);

		$display("covered %0d items (%0d directed rows), %0d register writes, %0d random settings",
			items_sent, directed_rows.size(), reg_writes, settings_run);
		$display("compared %0d results, %0d of them with a phase wrap", results_seen, wraps_seen);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", error_count);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
